// ===== src/lumi_pkg.sv =====
// Shared constants, types and fixed-point helpers for the LU matrix inverse block.
`default_nettype none
package lumi_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam logic [3:0] SIZE_AT_RESET = 4'd3;
    localparam int Q_W = 32;
    localparam int DIV_STEPS = 48;

    typedef logic signed [Q_W-1:0] t_q;

    localparam t_q Q_ONE = 32'sh0001_0000;
    localparam t_q Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN = 32'sh8000_0000;

    // Floor shift of a full product by 16, then clamp to the Q16.16 range.
    function automatic t_q sat_prod(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        if (s > 64'sh0000_0000_7FFF_FFFF) begin
            return Q_MAX;
        end else if (s < -64'sh0000_0000_8000_0000) begin
            return Q_MIN;
        end else begin
            return s[31:0];
        end
    endfunction

    // Exact difference, clamped to the Q16.16 range.
    function automatic t_q sat_sub(input t_q a, input t_q b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] != d[31]) begin
            return d[32] ? Q_MIN : Q_MAX;
        end else begin
            return d[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/lumi_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lumi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/lumi_div.sv =====
// Bit-serial Q16.16 divider: one quotient bit per cycle, truncating, saturated.
`default_nettype none
module lumi_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire lumi_pkg::t_q  i_num,
    input  wire lumi_pkg::t_q  i_den,
    output logic               o_done,
    output lumi_pkg::t_q       o_quot
);

    localparam int NW = lumi_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_fin;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [NW-1:0]    r_num;
    logic [31:0]      r_den;
    logic             r_neg;
    logic [31:0]      mag_n;
    logic [31:0]      mag_d;
    logic [32:0]      rem_sh;
    logic [33:0]      diff;
    logic             ge;

    assign mag_n  = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign mag_d  = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign ge     = !diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {mag_n, 16'h0000};
            r_den <= mag_d;
            r_rem <= '0;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_num <= {r_num[NW-2:0], ge};
        end
        if (r_fin) begin
            if (r_neg) begin
                o_quot <= (r_num > NW'(64'h8000_0000)) ? lumi_pkg::Q_MIN
                                                       : 32'(-r_num);
            end else begin
                o_quot <= (r_num > NW'(64'h7FFF_FFFF)) ? lumi_pkg::Q_MAX
                                                       : r_num[31:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/lu_matrix_inverse_det.sv =====
// Top level: matrix loader, LU factor and substitution sequencer, result output.
//
// The block collects an N by N matrix of signed Q16.16 elements in row-major
// order, one per input beat, with N taken from the matrix_size register (0 acts
// as 1, values above MAX_ORDER act as MAX_ORDER). The last element starts an
// in-place Doolittle LU factorization without pivoting, the determinant is the
// product of the pivots, and forward and back substitution then build the
// inverse one column at a time in a second memory. The N*N inverse elements
// leave row-major, each beat carrying the determinant, with last set on the
// final one; after a zero pivot every beat has value and determinant zero and
// singular set. Input beats are accepted whenever valid while loading; from
// the last element until the last result beat is taken the input is stalled.
// The work is set by one shared multiply-subtract path, with two memory reads
// per term, and one serial divider for each quotient. Writing matrix_size drops
// a partially loaded matrix; the user must write it only while the block is
// idle, and the block itself does not enforce this.
`default_nettype none
module lu_matrix_inverse_det #(
    parameter int MAX_ORDER = lumi_pkg::MAX_ORDER_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [31:0]  i_element,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [31:0]       o_inverse_value,
    output logic [31:0]       o_determinant,
    output logic              o_singular,
    output logic              o_last,
    input  wire logic         i_cfg_we,
    input  wire logic [3:0]   i_cfg_data
);

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = IW + 1;
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_TGT   = 5'd1;
    localparam logic [4:0] S_TGT2  = 5'd2;
    localparam logic [4:0] S_RA    = 5'd3;
    localparam logic [4:0] S_RB    = 5'd4;
    localparam logic [4:0] S_MUL   = 5'd5;
    localparam logic [4:0] S_SHQ   = 5'd6;
    localparam logic [4:0] S_SUB   = 5'd7;
    localparam logic [4:0] S_FIN   = 5'd8;
    localparam logic [4:0] S_FIN2  = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_WR    = 5'd11;
    localparam logic [4:0] S_DET   = 5'd12;
    localparam logic [4:0] S_ORD   = 5'd13;
    localparam logic [4:0] S_OLD   = 5'd14;
    localparam logic [4:0] S_OWAIT = 5'd15;

    localparam logic [1:0] MD_LU   = 2'd0;
    localparam logic [1:0] MD_FWD  = 2'd1;
    localparam logic [1:0] MD_BACK = 2'd2;

    logic [4:0]          r_state;
    logic [1:0]          r_mode;
    logic [IW-1:0]       r_r;
    logic [IW-1:0]       r_c;
    logic [CW-1:0]       r_t;
    logic [3:0]          r_size;
    lumi_pkg::t_q        r_acc;
    lumi_pkg::t_q        r_a;
    lumi_pkg::t_q        r_q;
    logic signed [63:0]  r_prod;
    lumi_pkg::t_q        r_det;
    logic                r_sing;
    logic                r_div_start;

    logic [3:0]          n4;
    logic [CW-1:0]       nm1;
    logic [CW-1:0]       t_end;
    logic                last_r;
    logic                last_c;
    logic                need_div;
    lumi_pkg::t_q        m_rdata;
    lumi_pkg::t_q        x_rdata;
    logic [AW-1:0]       m_raddr;
    logic [AW-1:0]       x_raddr;
    logic                m_we;
    logic [AW-1:0]       m_waddr;
    lumi_pkg::t_q        m_wdata;
    logic                x_we;
    lumi_pkg::t_q        mul_b;
    lumi_pkg::t_q        div_q;
    logic                div_done;
    logic                in_acc;

    // Effective matrix order.
    always_comb begin
        if (r_size == 4'd0) begin
            n4 = 4'd1;
        end else if (r_size > 4'(MAX_ORDER)) begin
            n4 = 4'(MAX_ORDER);
        end else begin
            n4 = r_size;
        end
    end
    assign nm1    = CW'(n4) - 1'b1;
    assign last_r = (CW'(r_r) == nm1);
    assign last_c = (CW'(r_c) == nm1);
    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_LOAD);

    // Exclusive end of the multiply-subtract term index for the current target element.
    always_comb begin
        case (r_mode)
            MD_LU:   t_end = (r_r < r_c) ? CW'(r_r) : CW'(r_c);
            MD_FWD:  t_end = CW'(r_r);
            default: t_end = CW'(n4);
        endcase
    end
    assign need_div = (r_mode == MD_BACK) || ((r_mode == MD_LU) && (r_r > r_c));

    // Memory address selection. The pivot address is held through the divider
    // launch so that the pivot is on the read port when the divider starts.
    always_comb begin
        unique case (r_state) inside
            S_RA:         m_raddr = {r_r, r_t[IW-1:0]};
            S_RB:         m_raddr = {r_t[IW-1:0], r_c};
            S_FIN, S_FIN2: m_raddr = (r_mode == MD_LU) ? {r_c, r_c} : {r_r, r_r};
            default:      m_raddr = {r_r, r_c};
        endcase
    end
    assign x_raddr = (r_state == S_RB) ? {r_t[IW-1:0], r_c} : {r_r, r_c};

    assign m_we    = (r_state == S_LOAD) ? in_acc : ((r_state == S_WR) && (r_mode == MD_LU));
    assign m_waddr = {r_r, r_c};
    assign m_wdata = (r_state == S_LOAD) ? i_element : r_acc;
    assign x_we    = (r_state == S_WR) && (r_mode != MD_LU);
    assign mul_b   = (r_mode == MD_LU) ? m_rdata : x_rdata;

    lumi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mstore (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    lumi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_xstore (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr ({r_r, r_c}),
        .i_wdata (r_acc),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    lumi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_acc),
        .i_den   (m_rdata),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_mode      <= MD_LU;
            r_r         <= '0;
            r_c         <= '0;
            r_t         <= '0;
            r_size      <= lumi_pkg::SIZE_AT_RESET;
            r_det       <= lumi_pkg::Q_ONE;
            r_sing      <= 1'b0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_we) begin
                        r_r <= '0;
                        r_c <= '0;
                    end else if (in_acc) begin
                        if (last_c) begin
                            r_c <= '0;
                            if (last_r) begin
                                r_r     <= '0;
                                r_mode  <= MD_LU;
                                r_det   <= lumi_pkg::Q_ONE;
                                r_sing  <= 1'b0;
                                r_state <= S_TGT;
                            end else begin
                                r_r <= r_r + 1'b1;
                            end
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                S_TGT: begin
                    r_t     <= (r_mode == MD_BACK) ? CW'(r_r) + 1'b1 : '0;
                    r_state <= S_TGT2;
                end
                S_TGT2: begin
                    r_state <= (r_t < t_end) ? S_RA : S_FIN;
                end
                S_RA:  r_state <= S_RB;
                S_RB:  r_state <= S_MUL;
                S_MUL: r_state <= S_SHQ;
                S_SHQ: r_state <= S_SUB;
                S_SUB: begin
                    r_t     <= r_t + 1'b1;
                    r_state <= ((r_t + 1'b1) < t_end) ? S_RA : S_FIN;
                end
                S_FIN: begin
                    r_state <= need_div ? S_FIN2 : S_WR;
                end
                S_FIN2: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if ((r_mode == MD_LU) && (r_r == r_c)) begin
                        if (r_acc == '0) begin
                            r_sing  <= 1'b1;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_state <= S_ORD;
                        end else begin
                            r_state <= S_DET;
                        end
                    end else begin
                        r_state <= S_TGT;
                        case (r_mode)
                            MD_LU: begin
                                if (last_r) begin
                                    r_r <= '0;
                                    if (last_c) begin
                                        r_c    <= '0;
                                        r_mode <= MD_FWD;
                                    end else begin
                                        r_c <= r_c + 1'b1;
                                    end
                                end else begin
                                    r_r <= r_r + 1'b1;
                                end
                            end
                            MD_FWD: begin
                                if (last_r) begin
                                    r_mode <= MD_BACK;
                                end else begin
                                    r_r <= r_r + 1'b1;
                                end
                            end
                            default: begin
                                if (r_r == '0) begin
                                    if (last_c) begin
                                        r_c     <= '0;
                                        r_state <= S_ORD;
                                    end else begin
                                        r_c    <= r_c + 1'b1;
                                        r_r    <= '0;
                                        r_mode <= MD_FWD;
                                    end
                                end else begin
                                    r_r <= r_r - 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_DET: begin
                    // Pivot element written; the diagonal element is never the last in
                    // its column unless it is the bottom row.
                    r_det   <= lumi_pkg::sat_prod(r_prod);
                    r_state <= S_TGT;
                    if (last_r) begin
                        r_r <= '0;
                        if (last_c) begin
                            r_c    <= '0;
                            r_mode <= MD_FWD;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end else begin
                        r_r <= r_r + 1'b1;
                    end
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    o_valid <= 1'b1;
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (last_c) begin
                            r_c <= '0;
                            if (last_r) begin
                                r_r     <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_r     <= r_r + 1'b1;
                                r_state <= S_ORD;
                            end
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_TGT2: begin
                if (r_mode == MD_LU) begin
                    r_acc <= m_rdata;
                end else if (r_mode == MD_BACK) begin
                    r_acc <= x_rdata;
                end else begin
                    r_acc <= (r_r == r_c) ? lumi_pkg::Q_ONE : '0;
                end
            end
            S_RB:   r_a <= m_rdata;
            S_MUL:  r_prod <= 64'(r_a) * 64'(mul_b);
            S_SHQ:  r_q <= lumi_pkg::sat_prod(r_prod);
            S_SUB:  r_acc <= lumi_pkg::sat_sub(r_acc, r_q);
            S_DIVW: begin
                if (div_done) begin
                    r_acc <= div_q;
                end
            end
            S_WR:   r_prod <= 64'(r_det) * 64'(r_acc);
            S_OLD: begin
                o_inverse_value <= r_sing ? 32'd0 : x_rdata;
                o_determinant   <= r_sing ? 32'd0 : r_det;
                o_singular      <= r_sing;
                o_last          <= last_r && last_c;
            end
            default: ;
        endcase
    end

    // A singular result carries zero value and zero determinant.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_inverse_value == 32'd0) && (o_determinant == 32'd0))
        else $error("singular beat with nonzero payload");

    // Input is never taken while a result beat is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while output pending");

    // A zero pivot ends factorization and goes straight to output.
    a_sing_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sing) |-> (r_state == S_ORD))
        else $error("zero pivot did not end factorization");

    // The divider only starts from its launch state.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIVW) && $past(r_state == S_FIN2))
        else $error("divider started out of sequence");

endmodule
`default_nettype wire
